/* hdl/sdspi_pkg.sv */
// ============================================================================
// SD card SPI host sequencer package
// Shared codes, configuration and result records and the CRC7 byte step.
// ============================================================================
package sdspi_pkg;

    // Operation codes of an input item.
    localparam logic [2:0] OP_BYTE        = 3'd0;
    localparam logic [2:0] OP_TICK        = 3'd1;
    localparam logic [2:0] OP_CONNECT     = 3'd2;
    localparam logic [2:0] OP_DISCONNECT  = 3'd3;
    localparam logic [2:0] OP_START_READ  = 3'd4;
    localparam logic [2:0] OP_READ_SECTOR = 3'd5;
    localparam logic [2:0] OP_STOP_READ   = 3'd6;
    localparam logic [2:0] OP_SYNC        = 3'd7;

    // Completion status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // Card conditions.
    localparam logic [1:0] CARD_UNLOADED = 2'd0;
    localparam logic [1:0] CARD_READY    = 2'd1;
    localparam logic [1:0] CARD_READING  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_DEADLINE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_DEADLINE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_DEADLINE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_DEADLINE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_DELAY    = 3'd4;

    localparam logic [15:0] RESET_DEADLINE_DEFAULT = 16'd1000;
    localparam logic [15:0] INIT_DEADLINE_DEFAULT  = 16'd1000;
    localparam logic [15:0] IDLE_DEADLINE_DEFAULT  = 16'd500;
    localparam logic [15:0] DATA_DEADLINE_DEFAULT  = 16'd100;
    localparam logic [9:0]  RETRY_DELAY_DEFAULT    = 10'd10;

    // Protocol sizes.
    localparam int SECTOR_BYTES   = 512;
    localparam int SECTOR_SHIFT   = $clog2(SECTOR_BYTES);
    localparam int CLEAR_BYTES    = 16;
    localparam int RESPONSE_TRIES = 9;
    localparam int IDLE_PROBES    = 16;

    typedef struct packed {
        logic [15:0] reset_deadline;
        logic [15:0] init_deadline;
        logic [15:0] idle_deadline;
        logic [15:0] data_deadline;
        logic [9:0]  retry_delay;
    } cfg_t;

    // Request to the CRC unit: command index and argument of a new frame.
    typedef struct packed {
        logic        start;
        logic [5:0]  cmd;
        logic [31:0] arg;
    } crc_req_t;

    typedef struct packed {
        logic       tx_request;
        logic [7:0] tx_byte;
        logic       chip_select;
        logic       slow_clock;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       data_last;
        logic       request_done;
        logic [1:0] status;
        logic [1:0] card_condition;
        logic       block_addressing;
    } res_t;

    // One byte through the CRC7 register, polynomial x^7 + x^3 + 1, MSB first.
    function automatic logic [6:0] crc7_byte(input logic [6:0] c, input logic [7:0] b);
        logic [6:0] r;
        logic       fb;
        r = c;
        for (int i = 7; i >= 0; i--)
        begin
            fb = b[i] ^ r[6];
            r  = {r[5:0], 1'b0};
            if (fb)
            begin
                r = r ^ 7'h09;
            end
        end
        return r;
    endfunction

endpackage

/* hdl/sd_card_spi_host_sequencer_unit.sv */
// ============================================================================
// SD card SPI host sequencer
// Top level: configuration registers, sequencer core, CRC unit, result stage.
// ============================================================================
// The block drives an SD card in SPI mode one event at a time. Each input
// item carries an operation (a byte exchange finished, a time tick, or a host
// request: connect, disconnect, start read, read sector, stop read, sync)
// and always yields exactly one result item: the next byte to exchange, the
// chip select and slow clock levels, a sector byte when one arrived, and a
// completion status when a request ends. An item is taken in every cycle in
// which the result register is empty or its item is being taken, so one
// item per clock is sustained; the result is registered and appears in the
// cycle after its item. The command CRC is worked out by a small unit one
// argument byte per cycle and is ready by the time the sixth frame byte is
// asked for. The five configuration registers hold the tick budgets and
// the retry pause; write them only while no request is running.
module sd_card_spi_host_sequencer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] block_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tx_request,
    output logic [7:0]  tx_byte,
    output logic        chip_select,
    output logic        slow_clock,
    output logic        data_valid,
    output logic [7:0]  data_byte,
    output logic        data_last,
    output logic        request_done,
    output logic [1:0]  status,
    output logic [1:0]  card_condition,
    output logic        block_addressing,
    input  logic        cfg_write_enable,
    input  logic [sdspi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import sdspi_pkg::*;

    cfg_t     cfg_reg;
    res_t     res_next;
    res_t     res_reg;
    logic     out_valid_reg;
    logic     accept;
    crc_req_t crc_req;
    logic [6:0] crc_value;

    // The result register frees up in the same cycle its item is taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Configuration writes land directly; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_deadline <= RESET_DEADLINE_DEFAULT;
            cfg_reg.init_deadline  <= INIT_DEADLINE_DEFAULT;
            cfg_reg.idle_deadline  <= IDLE_DEADLINE_DEFAULT;
            cfg_reg.data_deadline  <= DATA_DEADLINE_DEFAULT;
            cfg_reg.retry_delay    <= RETRY_DELAY_DEFAULT;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_RESET_DEADLINE: cfg_reg.reset_deadline <= cfg_data;
                CFG_INIT_DEADLINE:  cfg_reg.init_deadline  <= cfg_data;
                CFG_IDLE_DEADLINE:  cfg_reg.idle_deadline  <= cfg_data;
                CFG_DATA_DEADLINE:  cfg_reg.data_deadline  <= cfg_data;
                CFG_RETRY_DELAY:    cfg_reg.retry_delay    <= cfg_data[9:0];
                default:            cfg_reg.retry_delay    <= cfg_reg.retry_delay;
            endcase
        end
    end

    sdspi_crc u_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (crc_req),
        .crc   (crc_value)
    );

    sdspi_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .operation     (operation),
        .rx_byte       (rx_byte),
        .block_address (block_address),
        .cfg           (cfg_reg),
        .crc_value     (crc_value),
        .crc_req       (crc_req),
        .res           (res_next)
    );

    // Result stage: holds one result item until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign tx_request       = res_reg.tx_request;
    assign tx_byte          = res_reg.tx_byte;
    assign chip_select      = res_reg.chip_select;
    assign slow_clock       = res_reg.slow_clock;
    assign data_valid       = res_reg.data_valid;
    assign data_byte        = res_reg.data_byte;
    assign data_last        = res_reg.data_last;
    assign request_done     = res_reg.request_done;
    assign status           = res_reg.status;
    assign card_condition   = res_reg.card_condition;
    assign block_addressing = res_reg.block_addressing;

endmodule

/* hdl/sdspi_crc.sv */
// ============================================================================
// SD card SPI command CRC unit
// Computes the CRC7 of a command frame, one argument byte per cycle.
// ============================================================================
module sdspi_crc
(
    input  logic              clk,
    input  logic              rst_n,
    input  sdspi_pkg::crc_req_t req,
    output logic [6:0]        crc
);
    import sdspi_pkg::*;

    logic [6:0]  crc_reg, crc_next;
    logic [31:0] arg_reg, arg_next;
    logic [2:0]  cnt_reg, cnt_next;

    // The command byte is folded in at the start; the four argument bytes
    // follow, top byte first, and are all in before the CRC byte goes out.
    always_comb
    begin
        crc_next = crc_reg;
        arg_next = arg_reg;
        cnt_next = cnt_reg;
        if (req.start)
        begin
            crc_next = crc7_byte(7'd0, {2'b01, req.cmd});
            arg_next = req.arg;
            cnt_next = 3'd4;
        end
        else if (cnt_reg != 3'd0)
        begin
            crc_next = crc7_byte(crc_reg, arg_reg[31:24]);
            arg_next = {arg_reg[23:0], 8'h00};
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            crc_reg <= 7'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arg_reg <= arg_next;
    end

    assign crc = crc_reg;

endmodule

/* hdl/sdspi_core.sv */
// ============================================================================
// SD card SPI sequencer core
// Holds the sequencer state and works out one item's result and next state.
// ============================================================================
module sdspi_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [2:0]          operation,
    input  logic [7:0]          rx_byte,
    input  logic [31:0]         block_address,
    input  sdspi_pkg::cfg_t     cfg,
    input  logic [6:0]          crc_value,
    output sdspi_pkg::crc_req_t crc_req,
    output sdspi_pkg::res_t     res
);
    import sdspi_pkg::*;

    localparam logic [4:0] P_IDLE         = 5'd0;
    localparam logic [4:0] P_C_START      = 5'd1;
    localparam logic [4:0] P_C_ARM        = 5'd2;
    localparam logic [4:0] P_C_CMD0       = 5'd3;
    localparam logic [4:0] P_C_CMD0_CHK   = 5'd4;
    localparam logic [4:0] P_C_CMD8       = 5'd5;
    localparam logic [4:0] P_C_CMD8_CHK   = 5'd6;
    localparam logic [4:0] P_C_CMD55      = 5'd7;
    localparam logic [4:0] P_C_CMD55_CHK  = 5'd8;
    localparam logic [4:0] P_C_ACMD41     = 5'd9;
    localparam logic [4:0] P_C_ACMD41_CHK = 5'd10;
    localparam logic [4:0] P_C_RETRY      = 5'd11;
    localparam logic [4:0] P_C_CMD58      = 5'd12;
    localparam logic [4:0] P_C_CMD58_CHK  = 5'd13;
    localparam logic [4:0] P_C_CMD1       = 5'd14;
    localparam logic [4:0] P_C_CMD1_CHK   = 5'd15;
    localparam logic [4:0] P_C_CMD16      = 5'd16;
    localparam logic [4:0] P_C_CMD16_CHK  = 5'd17;
    localparam logic [4:0] P_D_SYNC       = 5'd18;
    localparam logic [4:0] P_D_CLEAR      = 5'd19;
    localparam logic [4:0] P_D_END        = 5'd20;
    localparam logic [4:0] P_Y_SYNC       = 5'd21;
    localparam logic [4:0] P_Y_END        = 5'd22;
    localparam logic [4:0] P_R_CMD        = 5'd23;
    localparam logic [4:0] P_R_CHK        = 5'd24;
    localparam logic [4:0] P_S_TOKEN      = 5'd25;
    localparam logic [4:0] P_S_CHK        = 5'd26;
    localparam logic [4:0] P_T_CMD        = 5'd27;
    localparam logic [4:0] P_T_CHK        = 5'd28;

    localparam logic [3:0] S_NONE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_IFAST = 4'd2;
    localparam logic [3:0] S_ISLOW = 4'd3;
    localparam logic [3:0] S_IWAIT = 4'd4;
    localparam logic [3:0] S_FRAME = 4'd5;
    localparam logic [3:0] S_R1    = 4'd6;
    localparam logic [3:0] S_TAIL  = 4'd7;
    localparam logic [3:0] S_DELAY = 4'd8;
    localparam logic [3:0] S_TOKEN = 4'd9;
    localparam logic [3:0] S_DATA  = 4'd10;
    localparam logic [3:0] S_CRC   = 4'd11;

    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_SEND_OP    = 6'd1;
    localparam logic [5:0] CMD_IF_COND    = 6'd8;
    localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
    localparam logic [5:0] CMD_READ_MULTI = 6'd18;
    localparam logic [5:0] CMD_SD_OP_COND = 6'd41;
    localparam logic [5:0] CMD_APP        = 6'd55;
    localparam logic [5:0] CMD_READ_OCR   = 6'd58;

    localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
    localparam logic [31:0] ARG_OP_COND = 32'h4000_01AA;
    localparam logic [39:0] STOP_FRAME  = 40'h4C_0000_0000;
    localparam logic [7:0]  STOP_CRC    = 8'h01;
    localparam logic [7:0]  R1_IDLE     = 8'h01;
    localparam logic [7:0]  R1_READY    = 8'h00;
    localparam logic [7:0]  R1_ILLEGAL  = 8'h05;
    localparam logic [7:0]  BUS_IDLE    = 8'hFF;
    localparam logic [7:0]  DATA_TOKEN  = 8'hFE;

    typedef struct packed {
        logic [4:0]  phase;
        logic [1:0]  card;
        logic        block_mode;
        logic [39:0] frame_hi;
        logic        stop_frame;
        logic [9:0]  byte_count;
        logic [4:0]  try_count;
        logic [15:0] deadline;
        logic [9:0]  delay;
        logic [7:0]  resp;
        logic [31:0] addr;
        logic [3:0]  sub;
        logic [15:0] idle_left;
        logic        cs;
        logic        slow;
        logic        want_frame;
        logic        want_tail;
        logic        release_end;
        logic        ocr_high;
    } st_t;

    typedef struct packed {
        st_t        st;
        logic       done;
        logic [1:0] status;
        crc_req_t   req;
    } adv_t;

    st_t st_reg, st_next;

    function automatic st_t start_cmd(input st_t s, input logic [5:0] cmd,
                                      input logic [31:0] arg, input logic idle,
                                      input logic tail, input logic rel);
        st_t r;
        r             = s;
        r.frame_hi    = {2'b01, cmd, arg};
        r.stop_frame  = 1'b0;
        r.want_frame  = 1'b1;
        r.want_tail   = tail;
        r.release_end = rel;
        r.cs          = 1'b1;
        r.byte_count  = 10'd0;
        r.try_count   = 5'd0;
        r.sub         = idle ? S_IFAST : S_FRAME;
        return r;
    endfunction

    function automatic st_t cmd_done(input st_t s);
        st_t r;
        r = s;
        if (r.release_end)
        begin
            r.cs = 1'b0;
        end
        r.sub = S_NONE;
        return r;
    endfunction

    // One step of the request sequence, taken when no byte stage is running.
    function automatic adv_t advance(input st_t s, input cfg_t c);
        adv_t a;
        a.st     = s;
        a.done   = 1'b0;
        a.status = ST_OK;
        a.req    = '0;
        case (s.phase)
            P_C_START:
            begin
                a.st.slow       = 1'b1;
                a.st.block_mode = 1'b0;
                a.st.cs         = 1'b0;
                a.st.byte_count = 10'd0;
                a.st.sub        = S_CLEAR;
                a.st.phase      = P_C_ARM;
            end
            P_C_ARM:
            begin
                a.st.deadline = c.reset_deadline;
                a.st.phase    = P_C_CMD0;
            end
            P_C_CMD0:
            begin
                a.st       = start_cmd(s, CMD_GO_IDLE, 32'd0, 1'b0, 1'b0, 1'b1);
                a.req      = '{1'b1, CMD_GO_IDLE, 32'd0};
                a.st.phase = P_C_CMD0_CHK;
            end
            P_C_CMD0_CHK:
            begin
                if (s.resp == R1_IDLE)
                begin
                    a.st.phase = P_C_CMD8;
                end
                else if (s.deadline == 16'd0)
                begin
                    a.st.card  = CARD_UNLOADED;
                    a.st.phase = P_IDLE;
                    a.done     = 1'b1;
                    a.status   = ST_TIMEOUT;
                end
                else
                begin
                    a.st.delay = c.retry_delay;
                    a.st.sub   = S_DELAY;
                    a.st.phase = P_C_CMD0;
                end
            end
            P_C_CMD8:
            begin
                a.st       = start_cmd(s, CMD_IF_COND, ARG_IF_COND, 1'b1, 1'b1, 1'b1);
                a.req      = '{1'b1, CMD_IF_COND, ARG_IF_COND};
                a.st.phase = P_C_CMD8_CHK;
            end
            P_C_CMD8_CHK:
            begin
                a.st.deadline = c.init_deadline;
                a.st.phase    = (s.resp != R1_ILLEGAL) ? P_C_CMD55 : P_C_CMD1;
            end
            P_C_CMD55:
            begin
                a.st       = start_cmd(s, CMD_APP, 32'd0, 1'b1, 1'b0, 1'b1);
                a.req      = '{1'b1, CMD_APP, 32'd0};
                a.st.phase = P_C_CMD55_CHK;
            end
            P_C_CMD55_CHK:
            begin
                a.st.phase = (s.resp == R1_IDLE) ? P_C_ACMD41 : P_C_RETRY;
            end
            P_C_ACMD41:
            begin
                a.st       = start_cmd(s, CMD_SD_OP_COND, ARG_OP_COND, 1'b1, 1'b1, 1'b1);
                a.req      = '{1'b1, CMD_SD_OP_COND, ARG_OP_COND};
                a.st.phase = P_C_ACMD41_CHK;
            end
            P_C_ACMD41_CHK:
            begin
                a.st.phase = (s.resp == R1_READY) ? P_C_CMD58 : P_C_RETRY;
            end
            P_C_RETRY:
            begin
                if (s.deadline == 16'd0)
                begin
                    a.st.card  = CARD_UNLOADED;
                    a.st.phase = P_IDLE;
                    a.done     = 1'b1;
                    a.status   = ST_TIMEOUT;
                end
                else
                begin
                    a.st.delay = c.retry_delay;
                    a.st.sub   = S_DELAY;
                    a.st.phase = P_C_CMD55;
                end
            end
            P_C_CMD58:
            begin
                a.st          = start_cmd(s, CMD_READ_OCR, 32'd0, 1'b1, 1'b1, 1'b1);
                a.st.ocr_high = 1'b0;
                a.req         = '{1'b1, CMD_READ_OCR, 32'd0};
                a.st.phase    = P_C_CMD58_CHK;
            end
            P_C_CMD58_CHK:
            begin
                if (s.ocr_high)
                begin
                    a.st.block_mode = 1'b1;
                end
                a.st.slow  = 1'b0;
                a.st.phase = P_C_CMD16;
            end
            P_C_CMD1:
            begin
                a.st       = start_cmd(s, CMD_SEND_OP, 32'd0, 1'b1, 1'b0, 1'b1);
                a.req      = '{1'b1, CMD_SEND_OP, 32'd0};
                a.st.phase = P_C_CMD1_CHK;
            end
            P_C_CMD1_CHK:
            begin
                if (s.resp == R1_READY)
                begin
                    a.st.slow  = 1'b0;
                    a.st.phase = P_C_CMD16;
                end
                else if (s.resp != R1_IDLE)
                begin
                    a.st.card  = CARD_UNLOADED;
                    a.st.phase = P_IDLE;
                    a.done     = 1'b1;
                    a.status   = ST_FAULT;
                end
                else if (s.deadline == 16'd0)
                begin
                    a.st.card  = CARD_UNLOADED;
                    a.st.phase = P_IDLE;
                    a.done     = 1'b1;
                    a.status   = ST_TIMEOUT;
                end
                else
                begin
                    a.st.delay = c.retry_delay;
                    a.st.sub   = S_DELAY;
                    a.st.phase = P_C_CMD1;
                end
            end
            P_C_CMD16:
            begin
                a.st       = start_cmd(s, CMD_BLOCKLEN, 32'(SECTOR_BYTES),
                                       1'b1, 1'b0, 1'b1);
                a.req      = '{1'b1, CMD_BLOCKLEN, 32'(SECTOR_BYTES)};
                a.st.phase = P_C_CMD16_CHK;
            end
            P_C_CMD16_CHK:
            begin
                a.st.card  = (s.resp != R1_READY) ? CARD_UNLOADED : CARD_READY;
                a.st.phase = P_IDLE;
                a.done     = 1'b1;
                a.status   = (s.resp != R1_READY) ? ST_FAULT : ST_OK;
            end
            P_D_SYNC, P_Y_SYNC:
            begin
                a.st.want_frame  = 1'b0;
                a.st.want_tail   = 1'b0;
                a.st.release_end = 1'b1;
                a.st.cs          = 1'b1;
                a.st.try_count   = 5'd0;
                a.st.sub         = S_IFAST;
                a.st.phase       = (s.phase == P_D_SYNC) ? P_D_CLEAR : P_Y_END;
            end
            P_D_CLEAR:
            begin
                a.st.card       = CARD_UNLOADED;
                a.st.cs         = 1'b0;
                a.st.byte_count = 10'd0;
                a.st.sub        = S_CLEAR;
                a.st.phase      = P_D_END;
            end
            P_D_END, P_Y_END:
            begin
                a.st.phase = P_IDLE;
                a.done     = 1'b1;
                a.status   = ST_OK;
            end
            P_R_CMD:
            begin
                a.req = '{1'b1, CMD_READ_MULTI,
                          s.block_mode ? s.addr : (s.addr << SECTOR_SHIFT)};
                a.st       = start_cmd(s, CMD_READ_MULTI, a.req.arg, 1'b1, 1'b0, 1'b0);
                a.st.phase = P_R_CHK;
            end
            P_R_CHK:
            begin
                if (s.resp != R1_READY)
                begin
                    a.st.cs   = 1'b0;
                    a.st.card = CARD_READY;
                    a.status  = ST_FAULT;
                end
                a.st.phase = P_IDLE;
                a.done     = 1'b1;
            end
            P_S_TOKEN:
            begin
                a.st.deadline = c.data_deadline;
                a.st.sub      = S_TOKEN;
                a.st.phase    = P_S_CHK;
            end
            P_S_CHK:
            begin
                if (s.resp != DATA_TOKEN)
                begin
                    a.st.cs   = 1'b0;
                    a.st.card = CARD_READY;
                    a.status  = ST_TIMEOUT;
                end
                a.st.phase = P_IDLE;
                a.done     = 1'b1;
            end
            P_T_CMD:
            begin
                a.st.frame_hi    = STOP_FRAME;
                a.st.stop_frame  = 1'b1;
                a.st.want_frame  = 1'b1;
                a.st.want_tail   = 1'b0;
                a.st.release_end = 1'b1;
                a.st.byte_count  = 10'd0;
                a.st.sub         = S_FRAME;
                a.st.phase       = P_T_CHK;
            end
            P_T_CHK:
            begin
                a.st.card  = CARD_READY;
                a.st.phase = P_IDLE;
                a.done     = 1'b1;
                a.status   = ST_OK;
            end
            default:
            begin
                a.st.phase = P_IDLE;
            end
        endcase
        return a;
    endfunction

    st_t        s;
    adv_t       a1;
    adv_t       a2;
    logic       moved;
    logic       busy_sub;
    logic       r_done;
    logic [1:0] r_status;
    logic       r_valid;
    logic       r_last;
    logic [7:0] r_data;
    logic       tx;
    logic [7:0] txb;
    logic [9:0] bc_inc;
    logic [4:0] try_inc;
    logic [2:0] fidx;
    logic [39:0] fshift;

    assign busy_sub = (st_reg.sub != S_NONE) && (st_reg.sub != S_IWAIT)
                      && (st_reg.sub != S_DELAY);
    assign bc_inc   = st_reg.byte_count + 10'd1;
    assign try_inc  = st_reg.try_count + 5'd1;

    always_comb
    begin
        s        = st_reg;
        moved    = 1'b0;
        r_done   = 1'b0;
        r_status = ST_OK;
        r_valid  = 1'b0;
        r_last   = 1'b0;
        r_data   = 8'h00;
        a1       = '0;
        a2       = '0;
        crc_req  = '0;

        if (operation == OP_BYTE)
        begin
            if (busy_sub)
            begin
                moved = 1'b1;
                case (st_reg.sub)
                    S_CLEAR:
                    begin
                        s.byte_count = bc_inc;
                        if (bc_inc >= 10'(CLEAR_BYTES))
                        begin
                            s.sub = S_NONE;
                        end
                    end
                    S_IFAST:
                    begin
                        s.try_count = try_inc;
                        if (rx_byte == BUS_IDLE)
                        begin
                            if (s.want_frame)
                            begin
                                s.sub        = S_FRAME;
                                s.byte_count = 10'd0;
                            end
                            else
                            begin
                                s = cmd_done(s);
                            end
                        end
                        else if (try_inc >= 5'(IDLE_PROBES))
                        begin
                            s.idle_left = cfg.idle_deadline;
                            s.sub       = S_ISLOW;
                        end
                    end
                    S_ISLOW:
                    begin
                        if ((rx_byte == BUS_IDLE) || (st_reg.idle_left == 16'd0))
                        begin
                            if (s.want_frame)
                            begin
                                s.sub        = S_FRAME;
                                s.byte_count = 10'd0;
                            end
                            else
                            begin
                                s = cmd_done(s);
                            end
                        end
                        else
                        begin
                            s.delay = cfg.retry_delay;
                            s.sub   = S_IWAIT;
                        end
                    end
                    S_FRAME:
                    begin
                        s.byte_count = bc_inc;
                        if (bc_inc >= (st_reg.stop_frame ? 10'd7 : 10'd6))
                        begin
                            s.sub       = S_R1;
                            s.try_count = 5'd0;
                        end
                    end
                    S_R1:
                    begin
                        if ((rx_byte == BUS_IDLE) && (try_inc < 5'(RESPONSE_TRIES)))
                        begin
                            s.try_count = try_inc;
                        end
                        else
                        begin
                            s.try_count = try_inc;
                            s.resp      = rx_byte;
                            if (s.want_tail)
                            begin
                                s.sub        = S_TAIL;
                                s.byte_count = 10'd0;
                            end
                            else
                            begin
                                s = cmd_done(s);
                            end
                        end
                    end
                    S_TAIL:
                    begin
                        if (st_reg.byte_count == 10'd0)
                        begin
                            s.ocr_high = rx_byte[6];
                        end
                        s.byte_count = bc_inc;
                        if (bc_inc >= 10'd4)
                        begin
                            s = cmd_done(s);
                        end
                    end
                    S_TOKEN:
                    begin
                        if (rx_byte == DATA_TOKEN)
                        begin
                            s.resp       = rx_byte;
                            s.sub        = S_DATA;
                            s.byte_count = 10'd0;
                        end
                        else if (st_reg.deadline == 16'd0)
                        begin
                            s.resp = rx_byte;
                            s.sub  = S_NONE;
                        end
                    end
                    S_DATA:
                    begin
                        r_valid      = 1'b1;
                        r_data       = rx_byte;
                        s.byte_count = bc_inc;
                        if (bc_inc >= 10'(SECTOR_BYTES))
                        begin
                            r_last       = 1'b1;
                            s.sub        = S_CRC;
                            s.byte_count = 10'd0;
                        end
                    end
                    S_CRC:
                    begin
                        s.byte_count = bc_inc;
                        if (bc_inc >= 10'd2)
                        begin
                            s.sub = S_NONE;
                        end
                    end
                    default:
                    begin
                        s.sub = st_reg.sub;
                    end
                endcase
            end
        end
        else if (operation == OP_TICK)
        begin
            if (st_reg.deadline != 16'd0)
            begin
                s.deadline = st_reg.deadline - 16'd1;
            end
            if (st_reg.idle_left != 16'd0)
            begin
                s.idle_left = st_reg.idle_left - 16'd1;
            end
            if ((st_reg.sub == S_IWAIT) || (st_reg.sub == S_DELAY))
            begin
                if (st_reg.delay <= 10'd1)
                begin
                    s.delay = 10'd0;
                    s.sub   = (st_reg.sub == S_IWAIT) ? S_ISLOW : S_NONE;
                    moved   = 1'b1;
                end
                else
                begin
                    s.delay = st_reg.delay - 10'd1;
                end
            end
        end
        else if (st_reg.phase == P_IDLE)
        begin
            moved = 1'b1;
            case (operation)
                OP_CONNECT:
                begin
                    s.phase = P_C_START;
                end
                OP_DISCONNECT:
                begin
                    if (st_reg.card == CARD_UNLOADED)
                    begin
                        r_done = 1'b1;
                    end
                    else if (st_reg.card != CARD_READY)
                    begin
                        r_done   = 1'b1;
                        r_status = ST_INVALID;
                    end
                    else
                    begin
                        s.phase = P_D_SYNC;
                    end
                end
                OP_START_READ:
                begin
                    if (st_reg.card != CARD_READY)
                    begin
                        r_done   = 1'b1;
                        r_status = ST_INVALID;
                    end
                    else
                    begin
                        s.card  = CARD_READING;
                        s.addr  = block_address;
                        s.phase = P_R_CMD;
                    end
                end
                OP_READ_SECTOR:
                begin
                    if (st_reg.card != CARD_READING)
                    begin
                        r_done   = 1'b1;
                        r_status = ST_INVALID;
                    end
                    else
                    begin
                        s.phase = P_S_TOKEN;
                    end
                end
                OP_STOP_READ:
                begin
                    if (st_reg.card != CARD_READING)
                    begin
                        r_done   = 1'b1;
                        r_status = ST_INVALID;
                    end
                    else
                    begin
                        s.phase = P_T_CMD;
                    end
                end
                default:
                begin
                    s.phase = P_Y_SYNC;
                end
            endcase
        end

        // At most two sequence steps can follow one item before a byte stage,
        // a pause or the end of the request stops the chain.
        if (moved && (s.phase != P_IDLE) && (s.sub == S_NONE))
        begin
            a1       = advance(s, cfg);
            s        = a1.st;
            r_done   = r_done | a1.done;
            r_status = r_status | a1.status;
            if (a1.req.start)
            begin
                crc_req = a1.req;
            end
            if ((s.phase != P_IDLE) && (s.sub == S_NONE))
            begin
                a2       = advance(s, cfg);
                s        = a2.st;
                r_done   = r_done | a2.done;
                r_status = r_status | a2.status;
                if (a2.req.start)
                begin
                    crc_req = a2.req;
                end
            end
        end
        crc_req.start = crc_req.start & accept;
        st_next = s;
    end

    // Byte to send next, taken from the final state of this item.
    assign fidx   = s.byte_count[2:0];
    assign fshift = s.frame_hi >> (6'd32 - {fidx, 3'b000});

    always_comb
    begin
        tx  = moved && (s.sub != S_NONE) && (s.sub != S_IWAIT) && (s.sub != S_DELAY);
        txb = 8'h00;
        if (tx)
        begin
            txb = BUS_IDLE;
            if ((s.sub == S_FRAME) && (s.byte_count < 10'd6))
            begin
                if (s.byte_count < 10'd5)
                begin
                    txb = fshift[7:0];
                end
                else
                begin
                    txb = s.stop_frame ? STOP_CRC : {crc_value, 1'b1};
                end
            end
        end
    end

    always_comb
    begin
        res.tx_request       = tx;
        res.tx_byte          = txb;
        res.chip_select      = s.cs;
        res.slow_clock       = s.slow;
        res.data_valid       = r_valid;
        res.data_byte        = r_data;
        res.data_last        = r_last;
        res.request_done     = r_done;
        res.status           = r_done ? r_status : ST_OK;
        res.card_condition   = s.card;
        res.block_addressing = s.block_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= '0;
            st_reg.resp <= BUS_IDLE;
        end
        else if (accept)
        begin
            st_reg <= st_next;
        end
    end

endmodule
